@@ design/tdi_pkg.sv @@
// ----------------------------------------------------------------------------
// tdi_pkg
// Shared constants, codes and controller/datapath handshake types for the
// timestamped direction interpolator.
// ----------------------------------------------------------------------------
package tdi_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 6;

    // last counter value of each counted iterative phase
    localparam logic [CNT_W-1:0] MUL_LAST  = 6'd11;
    localparam logic [CNT_W-1:0] SQ_LAST   = 6'd5;
    localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd30;

    localparam logic       MODE_ADD   = 1'b0;
    localparam logic [1:0] SRC_EMPTY  = 2'd0;
    localparam logic [1:0] SRC_INTERP = 2'd1;
    localparam logic [1:0] SRC_STORED = 2'd2;

    // [0] x, [1] y, [2] z
    typedef logic [2:0][31:0] t_vec;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_WALK, ST_WSHIFT, ST_MUL, ST_MAG, ST_NORM,
        ST_SQ, ST_SQRT0, ST_SQRT, ST_DIV0, ST_DIV, ST_FIN
    } t_state;

    typedef enum logic [1:0] {RD_NONE, RD_NEWEST, RD_PP, RD_PPP} t_rd_sel;

    typedef enum logic [2:0] {
        OUT_NONE, OUT_EMPTY, OUT_CUR, OUT_RD, OUT_INTERP
    } t_out_sel;

    typedef struct packed {
        logic     add_wr;
        logic     get_init;
        t_rd_sel  rd_sel;
        logic     load_cur;
        logic     step;
        logic     blend_init;
        logic     wshift;
        logic     mul_step;
        logic     mag_load;
        logic     norm_shift;
        logic     sq_step;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     cnt_clr;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic             newest_valid;
        logic             pp_valid;
        logic             ppp_valid;
        logic             pp_is_newest;
        logic             bracket;
        logic             times_eq;
        logic             w_fit;
        logic             mx_zero;
        logic             mag_fit;
        logic [CNT_W-1:0] cnt;
    } t_stat;

endpackage

@@ design/tdi_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdi_ctrl
// Sequencer: store writes, backward walk, blend, normalize, root and divide.
// ----------------------------------------------------------------------------
module tdi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_mode,
    input  tdi_pkg::t_stat i_stat,
    output tdi_pkg::t_cmd  o_cmd,
    output logic          busy
);

    tdi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != tdi_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel  = tdi_pkg::RD_NONE;
        o_cmd.out_sel = tdi_pkg::OUT_NONE;
        unique case (r_state)
            tdi_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_mode == tdi_pkg::MODE_ADD) begin
                        o_cmd.add_wr = 1'b1;
                    end else begin
                        o_cmd.get_init = 1'b1;
                        if (i_stat.newest_valid) begin
                            o_cmd.rd_sel = tdi_pkg::RD_NEWEST;
                            n_state      = tdi_pkg::ST_LOAD;
                        end else begin
                            o_cmd.out_sel = tdi_pkg::OUT_EMPTY;
                        end
                    end
                end
            end
            tdi_pkg::ST_LOAD: begin
                o_cmd.load_cur = 1'b1;
                if (!i_stat.pp_valid) begin
                    o_cmd.out_sel = tdi_pkg::OUT_RD;
                    n_state       = tdi_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_sel = tdi_pkg::RD_PP;
                    n_state      = tdi_pkg::ST_WALK;
                end
            end
            tdi_pkg::ST_WALK: begin
                if (i_stat.bracket) begin
                    if (i_stat.times_eq) begin
                        o_cmd.out_sel = tdi_pkg::OUT_CUR;
                        n_state       = tdi_pkg::ST_IDLE;
                    end else begin
                        o_cmd.blend_init = 1'b1;
                        o_cmd.cnt_clr    = 1'b1;
                        n_state          = tdi_pkg::ST_WSHIFT;
                    end
                end else begin
                    // advance one slot back
                    o_cmd.step = 1'b1;
                    if (i_stat.pp_is_newest || !i_stat.ppp_valid) begin
                        o_cmd.out_sel = tdi_pkg::OUT_RD;
                        n_state       = tdi_pkg::ST_IDLE;
                    end else begin
                        o_cmd.rd_sel = tdi_pkg::RD_PPP;
                    end
                end
            end
            tdi_pkg::ST_WSHIFT: begin
                if (i_stat.w_fit) begin
                    n_state = tdi_pkg::ST_MUL;
                end else begin
                    o_cmd.wshift = 1'b1;
                end
            end
            tdi_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.cnt == tdi_pkg::MUL_LAST) begin
                    n_state = tdi_pkg::ST_MAG;
                end
            end
            tdi_pkg::ST_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state        = tdi_pkg::ST_NORM;
            end
            tdi_pkg::ST_NORM: begin
                if (i_stat.mx_zero) begin
                    o_cmd.out_sel = tdi_pkg::OUT_CUR;
                    n_state       = tdi_pkg::ST_IDLE;
                end else if (i_stat.mag_fit) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = tdi_pkg::ST_SQ;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            tdi_pkg::ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_stat.cnt == tdi_pkg::SQ_LAST) begin
                    n_state = tdi_pkg::ST_SQRT0;
                end
            end
            tdi_pkg::ST_SQRT0: begin
                o_cmd.sqrt_init = 1'b1;
                o_cmd.cnt_clr   = 1'b1;
                n_state         = tdi_pkg::ST_SQRT;
            end
            tdi_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.cnt == tdi_pkg::SQRT_LAST) begin
                    n_state = tdi_pkg::ST_DIV0;
                end
            end
            tdi_pkg::ST_DIV0: begin
                o_cmd.div_init = 1'b1;
                o_cmd.cnt_clr  = 1'b1;
                n_state        = tdi_pkg::ST_DIV;
            end
            tdi_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.cnt == tdi_pkg::DIV_LAST) begin
                    n_state = tdi_pkg::ST_FIN;
                end
            end
            tdi_pkg::ST_FIN: begin
                o_cmd.out_sel = tdi_pkg::OUT_INTERP;
                n_state       = tdi_pkg::ST_IDLE;
            end
            default: begin
                n_state = tdi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/tdi_dpath.sv @@
// ----------------------------------------------------------------------------
// tdi_dpath
// Sample store, walk registers, shared multiplier, integer root, dividers
// and result register.
// ----------------------------------------------------------------------------
module tdi_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdi_pkg::t_cmd         i_cmd,
    output tdi_pkg::t_stat        o_stat,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic signed [63:0]   i_time_us,
    output logic                 o_strobe,
    output logic signed [31:0]   o_dir_x,
    output logic signed [31:0]   o_dir_y,
    output logic signed [31:0]   o_dir_z,
    output logic [1:0]           o_source
);

    localparam int IW = tdi_pkg::IDX_W;

    // sample store
    tdi_pkg::t_vec r_mem_v [tdi_pkg::DEPTH];
    logic [63:0]   r_mem_t [tdi_pkg::DEPTH];
    logic [tdi_pkg::DEPTH-1:0] r_valid;
    logic [IW-1:0] r_newest, r_p;

    tdi_pkg::t_vec r_rd_v, r_cur_v;
    logic [63:0]   r_rd_t, r_cur_t, r_t;

    logic [63:0]   r_w0, r_w1, w_or;
    logic signed [63:0] r_prod;
    logic [2:0][63:0] r_acc, r_mag;
    logic [2:0]    r_neg;
    logic [63:0]   r_sumsq, r_sq_n, r_res, r_bit;
    logic [2:0][31:0] r_rem;
    logic [2:0][30:0] r_low, r_q;
    logic [tdi_pkg::CNT_W-1:0] r_cnt;

    logic [IW-1:0] pp, ppp, wr_slot, rd_addr;
    logic [63:0]   t_flip, m01, mx, sq_try;
    logic [2:0]    mul_j;
    logic [1:0]    mul_c;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [31:0]   norm;
    logic [61:0]   num [3];
    logic [32:0]   dtry [3];

    assign pp      = (r_p == '0) ? IW'(tdi_pkg::DEPTH - 1) : r_p - 1'b1;
    assign ppp     = (pp == '0) ? IW'(tdi_pkg::DEPTH - 1) : pp - 1'b1;
    assign wr_slot = (r_newest == IW'(tdi_pkg::DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign t_flip  = {~i_time_us[63], i_time_us[62:0]};
    assign w_or    = r_w0 | r_w1;
    assign m01     = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign mx      = (m01 > r_mag[2]) ? m01 : r_mag[2];
    assign sq_try  = r_res + r_bit;
    assign norm    = r_res[31:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            tdi_pkg::RD_NEWEST: rd_addr = r_newest;
            tdi_pkg::RD_PP:     rd_addr = pp;
            tdi_pkg::RD_PPP:    rd_addr = ppp;
            default:            rd_addr = r_p;
        endcase
    end

    // one shared multiplier: blend products, then squares
    always_comb begin
        if (i_cmd.sq_step) begin
            mul_j = {1'b0, r_cnt[2:1]};
            mul_c = r_cnt[2:1];
            mul_a = {1'b0, r_mag[mul_c][30:0]};
            mul_b = {1'b0, r_mag[mul_c][30:0]};
        end else begin
            mul_j = r_cnt[3:1];
            mul_c = mul_j[2:1];
            mul_a = mul_j[0] ? r_rd_v[mul_c] : r_cur_v[mul_c];
            mul_b = mul_j[0] ? {1'b0, r_w0[30:0]} : {1'b0, r_w1[30:0]};
        end
    end
    assign mul_p = mul_a * mul_b;

    // dividend is mag * 2^30 plus half the norm for rounding
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num[c]  = {1'b0, r_mag[c][30:0], 30'd0} + {31'd0, norm[31:1]};
            dtry[c] = {r_rem[c], r_low[c][30]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_mem_v[wr_slot] <= {i_pos_z, i_pos_y, i_pos_x};
            r_mem_t[wr_slot] <= t_flip;
        end
        if (i_cmd.rd_sel != tdi_pkg::RD_NONE) begin
            r_rd_v <= r_mem_v[rd_addr];
            r_rd_t <= r_mem_t[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_newest <= '0;
            r_p      <= '0;
            r_cnt    <= '0;
            o_strobe <= 1'b0;
        end else begin
            if (i_cmd.add_wr) begin
                r_valid[wr_slot] <= 1'b1;
                r_newest         <= wr_slot;
            end
            if (i_cmd.get_init) begin
                r_p <= r_newest;
            end
            if (i_cmd.step) begin
                r_p <= pp;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.mul_step || i_cmd.sq_step || i_cmd.sqrt_step ||
                         i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            o_strobe <= (i_cmd.out_sel != tdi_pkg::OUT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.get_init) begin
            r_t <= t_flip;
        end
        if (i_cmd.load_cur || i_cmd.step) begin
            r_cur_v <= r_rd_v;
            r_cur_t <= r_rd_t;
        end
        if (i_cmd.blend_init) begin
            r_w1  <= r_t - r_rd_t;
            r_w0  <= r_cur_t - r_t;
            r_acc <= '0;
        end
        if (i_cmd.wshift) begin
            // shifting in one go by 8 equals eight single shifts
            if (|w_or[63:39]) begin
                r_w0 <= r_w0 >> 8;
                r_w1 <= r_w1 >> 8;
            end else begin
                r_w0 <= r_w0 >> 1;
                r_w1 <= r_w1 >> 1;
            end
        end
        if (i_cmd.mul_step || i_cmd.sq_step) begin
            if (!r_cnt[0]) begin
                r_prod <= mul_p;
            end else if (i_cmd.mul_step) begin
                r_acc[mul_c] <= r_acc[mul_c] + r_prod;
            end else begin
                r_sumsq <= r_sumsq + r_prod;
            end
        end
        if (i_cmd.mag_load) begin
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= r_acc[c][63];
                r_mag[c] <= r_acc[c][63] ? (64'd0 - r_acc[c]) : r_acc[c];
            end
            r_sumsq <= '0;
        end
        if (i_cmd.norm_shift) begin
            for (int c = 0; c < 3; c++) begin
                if (|mx[63:39]) begin
                    r_mag[c] <= r_mag[c] >> 8;
                end else if (|mx[63:31]) begin
                    r_mag[c] <= r_mag[c] >> 1;
                end else if (mx[63:22] == '0) begin
                    r_mag[c] <= r_mag[c] << 8;
                end else begin
                    r_mag[c] <= r_mag[c] << 1;
                end
            end
        end
        if (i_cmd.sqrt_init) begin
            r_sq_n <= r_sumsq;
            r_res  <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sq_n >= sq_try) begin
                r_sq_n <= r_sq_n - sq_try;
                r_res  <= (r_res >> 1) + r_bit;
            end else begin
                r_res  <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= {1'b0, num[c][61:31]};
                r_low[c] <= num[c][30:0];
                r_q[c]   <= '0;
            end
        end
        if (i_cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if (dtry[c] >= {1'b0, norm}) begin
                    r_rem[c] <= 32'(dtry[c] - {1'b0, norm});
                    r_q[c]   <= {r_q[c][29:0], 1'b1};
                end else begin
                    r_rem[c] <= dtry[c][31:0];
                    r_q[c]   <= {r_q[c][29:0], 1'b0};
                end
                r_low[c] <= {r_low[c][29:0], 1'b0};
            end
        end
        unique case (i_cmd.out_sel)
            tdi_pkg::OUT_EMPTY: begin
                o_dir_x  <= '0;
                o_dir_y  <= '0;
                o_dir_z  <= '0;
                o_source <= tdi_pkg::SRC_EMPTY;
            end
            tdi_pkg::OUT_CUR: begin
                o_dir_x  <= r_cur_v[0];
                o_dir_y  <= r_cur_v[1];
                o_dir_z  <= r_cur_v[2];
                o_source <= tdi_pkg::SRC_STORED;
            end
            tdi_pkg::OUT_RD: begin
                o_dir_x  <= r_rd_v[0];
                o_dir_y  <= r_rd_v[1];
                o_dir_z  <= r_rd_v[2];
                o_source <= tdi_pkg::SRC_STORED;
            end
            tdi_pkg::OUT_INTERP: begin
                o_dir_x  <= r_neg[0] ? 32'd0 - {1'b0, r_q[0]} : {1'b0, r_q[0]};
                o_dir_y  <= r_neg[1] ? 32'd0 - {1'b0, r_q[1]} : {1'b0, r_q[1]};
                o_dir_z  <= r_neg[2] ? 32'd0 - {1'b0, r_q[2]} : {1'b0, r_q[2]};
                o_source <= tdi_pkg::SRC_INTERP;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.newest_valid = r_valid[r_newest];
        o_stat.pp_valid     = r_valid[pp];
        o_stat.ppp_valid    = r_valid[ppp];
        o_stat.pp_is_newest = (pp == r_newest);
        o_stat.bracket      = (r_rd_t <= r_t) && (r_t <= r_cur_t);
        o_stat.times_eq     = (r_rd_t == r_cur_t);
        o_stat.w_fit        = (w_or[63:31] == '0);
        o_stat.mx_zero      = (mx == '0);
        o_stat.mag_fit      = (mx[63:31] == '0) && mx[30];
        o_stat.cnt          = r_cnt;
    end

    a_add_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |=> r_valid[r_newest])
        else $error("newest slot not valid after add");

    a_sq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_step |-> (mx[63:31] == '0) && mx[30])
        else $error("magnitudes not normalized before squaring");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> (r_res[63:32] == '0) && (r_res[31] || r_res[30]))
        else $error("norm out of range");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem[0] < norm) && (r_rem[1] < norm) && (r_rem[2] < norm))
        else $error("division remainder not below divisor");

endmodule

@@ design/timestamped_direction_interpolator.sv @@
// ----------------------------------------------------------------------------
// timestamped_direction_interpolator
// Ring of timestamped unit directions; queries blend the bracketing pair.
//
//   channel   handshake             payload
//   request   start / busy          i_mode, i_pos_x/y/z, i_time_us
//   result    o_strobe (1 cycle)    o_dir_x/y/z, o_source
//
// An add writes the next slot and gives no result. A get walks the store one
// slot per cycle through the single read port, then a blend forms six
// products on the shared multiplier, squares the normalized magnitudes and
// runs the bit-pair square root and the three parallel restoring dividers.
// Synchronous active-low reset clears the valid bits and the newest pointer.
// The result cannot be stalled; it shows for one cycle.
// ----------------------------------------------------------------------------
module timestamped_direction_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [63:0] i_time_us,
    output logic               o_strobe,
    output logic signed [31:0] o_dir_x,
    output logic signed [31:0] o_dir_y,
    output logic signed [31:0] o_dir_z,
    output logic [1:0]         o_source
);

    tdi_pkg::t_cmd  cmd;
    tdi_pkg::t_stat stat;

    tdi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    tdi_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_time_us (i_time_us),
        .o_strobe  (o_strobe),
        .o_dir_x   (o_dir_x),
        .o_dir_y   (o_dir_y),
        .o_dir_z   (o_dir_z),
        .o_source  (o_source)
    );

endmodule
